@@ sv/prim_minimum_spanning_tree_defines.svh @@
// assertion macros for the port-level checker
`ifndef PRIM_MINIMUM_SPANNING_TREE_DEFINES_SVH
`define PRIM_MINIMUM_SPANNING_TREE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PMST_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define PMST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/prim_mst_pkg.sv @@
// ----------------------------------------------------------------------------
// prim_mst_pkg
// shared types and codes of the spanning tree block: key unit operations and
// the control and status groups between sequencer and key unit
// ----------------------------------------------------------------------------
package prim_mst_pkg;

   localparam int OP_BITS = 3;

   localparam logic [OP_BITS-1:0] OP_IDLE  = 3'd0;
   localparam logic [OP_BITS-1:0] OP_INIT  = 3'd1;
   localparam logic [OP_BITS-1:0] OP_SCAN  = 3'd2;
   localparam logic [OP_BITS-1:0] OP_JOIN  = 3'd3;
   localparam logic [OP_BITS-1:0] OP_RELAX = 3'd4;

   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic               first;
   } key_ctrl_type;

   typedef struct packed {
      logic found;
      logic joined;
   } key_stat_type;

endpackage

@@ sv/prim_mst_mem.sv @@
// ----------------------------------------------------------------------------
// prim_mst_mem
// adjacency store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module prim_mst_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 16
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/prim_mst_keys.sv @@
// ----------------------------------------------------------------------------
// prim_mst_keys
// per-vertex keys, parents and tree membership with the one shared compare
// unit, used both for the minimum scan and for edge relaxation
// ----------------------------------------------------------------------------
module prim_mst_keys
   import prim_mst_pkg::*;
#(
   parameter int NUM_VERTICES = 8,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  key_ctrl_type                        ctrl,
   input  logic [$clog2(NUM_VERTICES)-1:0]     idx,
   input  logic [WEIGHT_BITS-1:0]              weight,
   output key_stat_type                        stat,
   output logic [$clog2(NUM_VERTICES)-1:0]     best_idx,
   output logic [WEIGHT_BITS:0]                key_at,
   output logic [$clog2(NUM_VERTICES)-1:0]     parent_at
);

   localparam int IW = $clog2(NUM_VERTICES);
   localparam int KW = WEIGHT_BITS + 1;
   localparam logic [KW-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

   logic [KW-1:0]           key_ff [NUM_VERTICES];
   logic [IW-1:0]           parent_ff [NUM_VERTICES];
   logic [NUM_VERTICES-1:0] in_tree_ff;
   logic [KW-1:0]           best_key_ff;
   logic [IW-1:0]           best_idx_ff;
   logic                    found_ff;
   logic [IW-1:0]           u_ff;

   logic [KW-1:0] cur_best;
   logic [KW-1:0] cmp_a;
   logic [KW-1:0] cmp_b;
   logic          less;
   logic          free_at;
   logic          take_scan;
   logic          take_relax;

   assign key_at    = key_ff[idx];
   assign parent_at = parent_ff[idx];
   assign free_at   = !in_tree_ff[idx];
   assign cur_best  = ctrl.first ? KEY_INF : best_key_ff;

   // shared comparator: scan asks key < best, relax asks weight < key
   always_comb begin
      if (ctrl.op == OP_RELAX) begin
         cmp_a = KW'(weight);
         cmp_b = key_at;
      end else begin
         cmp_a = key_at;
         cmp_b = cur_best;
      end
   end

   assign less       = cmp_a < cmp_b;
   assign take_scan  = (ctrl.op == OP_SCAN) && free_at && less;
   assign take_relax = (ctrl.op == OP_RELAX) && (weight != '0) && free_at && less;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_tree_ff <= '0;
      end else if (ctrl.op == OP_INIT) begin
         in_tree_ff <= '0;
      end else if (ctrl.op == OP_JOIN && found_ff) begin
         in_tree_ff[best_idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.op == OP_INIT) begin
         for (int i = 0; i < NUM_VERTICES; i++) begin
            key_ff[i]    <= (i == 0) ? '0 : KEY_INF;
            parent_ff[i] <= '0;
         end
      end else if (take_relax) begin
         key_ff[idx]    <= cmp_a;
         parent_ff[idx] <= u_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (take_scan) begin
         best_key_ff <= key_at;
         best_idx_ff <= idx;
         found_ff    <= 1'b1;
      end else if (ctrl.op == OP_SCAN && ctrl.first) begin
         best_key_ff <= KEY_INF;
         found_ff    <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.op == OP_JOIN) begin
         u_ff <= best_idx_ff;
      end
   end

   assign best_idx    = best_idx_ff;
   assign stat.found  = found_ff;
   assign stat.joined = !free_at;

endmodule

@@ sv/prim_minimum_spanning_tree.sv @@
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree
// loads an adjacency matrix, runs prim's method from vertex 0 and reports
// the tree edge of every other vertex
// ----------------------------------------------------------------------------
//   channel  direction  contents
//   req_*    in         row, col, weight, last_entry (one matrix entry)
//   rsp_*    out        vertex, parent, edge weight, reachable, total, last
//
// an entry without last_entry only updates the adjacency memory. with
// last_entry the run initializes the keys, then alternates scan and relax
// passes through the shared key compare unit until no free vertex is
// reachable, then gives one result per vertex 1..N-1 and a clearing pass of
// the adjacency memory (one entry a cycle). reset starts with the same
// clearing pass. req_ready is low from the last entry until the clearing
// pass ends; a stalled result holds the output register and pauses the result phase.
// ----------------------------------------------------------------------------
module prim_minimum_spanning_tree
   import prim_mst_pkg::*;
#(
   parameter int NUM_VERTICES = 8,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_row,
   input  logic [2:0]  req_col,
   input  logic [15:0] req_weight,
   input  logic        req_last_entry,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_vertex,
   output logic [2:0]  rsp_parent_vertex,
   output logic [15:0] rsp_edge_weight,
   output logic        rsp_reachable,
   output logic [18:0] rsp_total_cost,
   output logic        rsp_last
);

   localparam int IW    = $clog2(NUM_VERTICES);
   localparam int DEPTH = NUM_VERTICES * NUM_VERTICES;
   localparam int AW    = $clog2(DEPTH);
   localparam int KW    = WEIGHT_BITS + 1;
   localparam int SW    = (KW > 19) ? KW : 19;

   localparam logic [IW-1:0] LAST_IDX  = IW'(NUM_VERTICES - 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   localparam logic [2:0] S_LOAD  = 3'd0;
   localparam logic [2:0] S_INIT  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_JOIN  = 3'd3;
   localparam logic [2:0] S_RELAX = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;
   localparam logic [2:0] S_CLEAR = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [18:0]   cost_ff, cost_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  vertex_ff, vertex_in;
   logic [2:0]  parent_ff, parent_in;
   logic [15:0] edge_ff, edge_in;
   logic        reach_ff, reach_in;
   logic [18:0] total_ff, total_in;
   logic        last_ff, last_in;

   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [WEIGHT_BITS-1:0] mem_wdata;
   logic [AW-1:0]          mem_raddr;
   logic [WEIGHT_BITS-1:0] mem_rdata;

   key_ctrl_type  kctrl;
   key_stat_type  kstat;
   logic [IW-1:0] best_idx;
   logic [KW-1:0] key_at;
   logic [IW-1:0] parent_at;

   logic                   ld_hit;
   logic [AW-1:0]          ld_addr;
   logic [WEIGHT_BITS-1:0] ld_weight;
   logic [AW-1:0]          join_addr;
   logic [KW-1:0]          edge_w;
   logic                   out_fire;

   assign ld_hit    = (int'(req_row) < NUM_VERTICES) && (int'(req_col) < NUM_VERTICES);
   assign ld_addr   = AW'(int'(req_row) * NUM_VERTICES + int'(req_col));
   assign ld_weight = WEIGHT_BITS'(req_weight);
   assign join_addr = AW'(int'(best_idx) * NUM_VERTICES);
   assign edge_w    = kstat.joined ? key_at : '0;
   assign out_fire  = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == S_LOAD);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      addr_in      = addr_ff;
      clr_in       = clr_ff;
      cost_in      = cost_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      vertex_in    = vertex_ff;
      parent_in    = parent_ff;
      edge_in      = edge_ff;
      reach_in     = reach_ff;
      total_in     = total_ff;
      last_in      = last_ff;
      kctrl.op     = OP_IDLE;
      kctrl.first  = (idx_ff == '0);
      mem_we       = 1'b0;
      mem_waddr    = clr_ff;
      mem_wdata    = '0;
      mem_raddr    = addr_ff;

      unique case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               if (ld_hit) begin
                  mem_we    = 1'b1;
                  mem_waddr = ld_addr;
                  mem_wdata = ld_weight;
               end
               if (req_last_entry) begin
                  state_in = S_INIT;
               end
            end
         end
         S_INIT: begin
            kctrl.op = OP_INIT;
            cost_in  = '0;
            idx_in   = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            kctrl.op = OP_SCAN;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = S_JOIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_JOIN: begin
            kctrl.op = OP_JOIN;
            if (kstat.found) begin
               // fetch the first entry of the new tree vertex's row
               mem_raddr = join_addr;
               addr_in   = join_addr;
               idx_in    = '0;
               state_in  = S_RELAX;
            end else begin
               idx_in   = IW'(1);
               state_in = S_OUT;
            end
         end
         S_RELAX: begin
            kctrl.op = OP_RELAX;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = S_SCAN;
            end else begin
               idx_in    = idx_ff + 1'b1;
               mem_raddr = addr_ff + 1'b1;
               addr_in   = addr_ff + 1'b1;
            end
         end
         S_OUT: begin
            if (out_fire) begin
               cost_in      = 19'(SW'(cost_ff) + SW'(edge_w));
               rsp_valid_in = 1'b1;
               vertex_in    = 3'(idx_ff);
               parent_in    = kstat.joined ? 3'(parent_at) : 3'd0;
               edge_in      = 16'(SW'(edge_w));
               reach_in     = kstat.joined;
               total_in     = 19'(SW'(cost_ff) + SW'(edge_w));
               last_in      = (idx_ff == LAST_IDX);
               if (idx_ff == LAST_IDX) begin
                  clr_in   = '0;
                  state_in = S_CLEAR;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_CLEAR: begin
            mem_we = 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = S_LOAD;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         default: begin
            clr_in   = '0;
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         clr_ff       <= '0;
         cost_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         clr_ff       <= clr_in;
         cost_ff      <= cost_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      vertex_ff <= vertex_in;
      parent_ff <= parent_in;
      edge_ff   <= edge_in;
      reach_ff  <= reach_in;
      total_ff  <= total_in;
      last_ff   <= last_in;
   end

   prim_mst_mem #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (WEIGHT_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   prim_mst_keys #(
      .NUM_VERTICES (NUM_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_keys (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (kctrl),
      .idx       (idx_ff),
      .weight    (mem_rdata),
      .stat      (kstat),
      .best_idx  (best_idx),
      .key_at    (key_at),
      .parent_at (parent_at)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_vertex        = vertex_ff;
   assign rsp_parent_vertex = parent_ff;
   assign rsp_edge_weight   = edge_ff;
   assign rsp_reachable     = reach_ff;
   assign rsp_total_cost    = total_ff;
   assign rsp_last          = last_ff;

endmodule

@@ sv/prim_mst_checker.sv @@
// ----------------------------------------------------------------------------
// prim_mst_checker
// port-level checks of the spanning tree block, attached by bind
// ----------------------------------------------------------------------------
`include "prim_minimum_spanning_tree_defines.svh"

module prim_mst_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last_entry,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_vertex,
   input logic [2:0]  rsp_parent_vertex,
   input logic [15:0] rsp_edge_weight,
   input logic        rsp_reachable,
   input logic [18:0] rsp_total_cost,
   input logic        rsp_last
);

   logic        req_fire;
   logic        rsp_fire;
   logic [42:0] rsp_payload;

   assign req_fire    = req_valid && req_ready;
   assign rsp_fire    = rsp_valid && rsp_ready;
   assign rsp_payload = {rsp_vertex, rsp_parent_vertex, rsp_edge_weight, rsp_reachable,
                         rsp_total_cost, rsp_last};

   // a stalled result stays offered
   `PMST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

   // a stalled result keeps its payload
   `PMST_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_payload), "result changed while stalled")

   // the final entry starts a run, so no entry is taken right after it
   `PMST_ASSERT_NEXT(a_busy_after_last, clock, reset, req_fire && req_last_entry, !req_ready, "entry taken right after the final entry")

   // while results of a run remain, loading stays closed
   `PMST_ASSERT_NEXT(a_busy_in_results, clock, reset, rsp_fire && !rsp_last, !req_ready, "entry taken before the run's results are done")

endmodule

bind prim_minimum_spanning_tree prim_mst_checker u_prim_mst_checker (.*);

@@ tb/prim_minimum_spanning_tree_checker.sv @@
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree_checker
// watches both channels of the spanning tree block, keeps its own copy of the
// adjacency matrix, solves each loaded graph and compares every tree edge
// ----------------------------------------------------------------------------
module prim_minimum_spanning_tree_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_row,
   input  logic [2:0]  req_col,
   input  logic [15:0] req_weight,
   input  logic        req_last_entry,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_vertex,
   input  logic [2:0]  rsp_parent_vertex,
   input  logic [15:0] rsp_edge_weight,
   input  logic        rsp_reachable,
   input  logic [18:0] rsp_total_cost,
   input  logic        rsp_last,
   output int          mismatches,
   output int          pending
);

   localparam int          NV      = 8;
   localparam logic [16:0] KEY_INF = 17'h10000;

   typedef struct packed {
      logic [2:0]  vertex;
      logic [2:0]  parent_vertex;
      logic [15:0] edge_weight;
      logic        reachable;
      logic [18:0] total_cost;
      logic        last;
   } tree_edge_type;

   logic [15:0]   weight_matrix [NV][NV];
   tree_edge_type tree_edges_due [$];

   task automatic clear_matrix();
      for (int r = 0; r < NV; r++) begin
         for (int c = 0; c < NV; c++) begin
            weight_matrix[r][c] = 16'd0;
         end
      end
   endtask

   // grow the tree from vertex 0, then queue one edge per vertex 1..NV-1
   task automatic solve_spanning_tree();
      logic [16:0]   key [NV];
      logic [2:0]    parent [NV];
      logic          joined [NV];
      logic [18:0]   cost;
      logic [16:0]   pick_key;
      int            pick;
      tree_edge_type edge_due;
      for (int i = 0; i < NV; i++) begin
         key[i]    = KEY_INF;
         parent[i] = 3'd0;
         joined[i] = 1'b0;
      end
      key[0] = 17'd0;
      cost   = 19'd0;
      for (int round = 0; round < NV; round++) begin
         pick     = NV;
         pick_key = KEY_INF;
         // strict compare keeps the lowest index on ties
         for (int i = 0; i < NV; i++) begin
            if (!joined[i] && key[i] < pick_key) begin
               pick_key = key[i];
               pick     = i;
            end
         end
         if (pick != NV) begin
            joined[pick] = 1'b1;
            for (int v = 0; v < NV; v++) begin
               if (weight_matrix[pick][v] != 16'd0 && !joined[v] &&
                   {1'b0, weight_matrix[pick][v]} < key[v]) begin
                  key[v]    = {1'b0, weight_matrix[pick][v]};
                  parent[v] = 3'(pick);
               end
            end
         end
      end
      for (int v = 1; v < NV; v++) begin
         edge_due.vertex        = 3'(v);
         edge_due.reachable     = joined[v];
         edge_due.parent_vertex = joined[v] ? parent[v] : 3'd0;
         edge_due.edge_weight   = joined[v] ? key[v][15:0] : 16'd0;
         if (joined[v]) cost = cost + 19'(key[v][15:0]);
         edge_due.total_cost    = cost;
         edge_due.last          = (v == NV - 1);
         tree_edges_due.push_back(edge_due);
      end
   endtask

   task automatic check_field(input string field, input longint unsigned expected,
                              input longint unsigned actual);
      if (expected != actual) begin
         $error("%s: expected %0d, actual %0d", field, expected, actual);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      tree_edge_type oldest;
      if (reset) begin
         clear_matrix();
         tree_edges_due.delete();
         mismatches = 0;
      end else begin
         if (req_valid && req_ready) begin
            weight_matrix[req_row][req_col] = req_weight;
            if (req_last_entry) begin
               solve_spanning_tree();
               clear_matrix();
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (tree_edges_due.size() == 0) begin
               $error("unexpected result transaction, vertex %0d", rsp_vertex);
               mismatches++;
            end else begin
               oldest = tree_edges_due.pop_front();
               check_field("vertex", oldest.vertex, rsp_vertex);
               check_field("parent_vertex", oldest.parent_vertex, rsp_parent_vertex);
               check_field("edge_weight", oldest.edge_weight, rsp_edge_weight);
               check_field("reachable", oldest.reachable, rsp_reachable);
               check_field("total_cost", oldest.total_cost, rsp_total_cost);
               check_field("last", oldest.last, rsp_last);
            end
         end
      end
      pending = tree_edges_due.size();
   end

endmodule

@@ tb/prim_minimum_spanning_tree_tb.sv @@
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree_tb
// loads directed and random graphs into the spanning tree block with random
// gaps and result stalls; the checker solves each graph and compares
// ----------------------------------------------------------------------------
module prim_minimum_spanning_tree_tb;

   localparam int ITEM_TARGET  = 300;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 100;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_row;
   logic [2:0]  req_col;
   logic [15:0] req_weight;
   logic        req_last_entry;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_vertex;
   logic [2:0]  rsp_parent_vertex;
   logic [15:0] rsp_edge_weight;
   logic        rsp_reachable;
   logic [18:0] rsp_total_cost;
   logic        rsp_last;

   int mismatches;
   int pending;
   int entries_sent;
   int cycle_count = 0;
   bit calm;

   prim_minimum_spanning_tree dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_row           (req_row),
      .req_col           (req_col),
      .req_weight        (req_weight),
      .req_last_entry    (req_last_entry),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_vertex        (rsp_vertex),
      .rsp_parent_vertex (rsp_parent_vertex),
      .rsp_edge_weight   (rsp_edge_weight),
      .rsp_reachable     (rsp_reachable),
      .rsp_total_cost    (rsp_total_cost),
      .rsp_last          (rsp_last)
   );

   prim_minimum_spanning_tree_checker tree_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_row           (req_row),
      .req_col           (req_col),
      .req_weight        (req_weight),
      .req_last_entry    (req_last_entry),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_vertex        (rsp_vertex),
      .rsp_parent_vertex (rsp_parent_vertex),
      .rsp_edge_weight   (rsp_edge_weight),
      .rsp_reachable     (rsp_reachable),
      .rsp_total_cost    (rsp_total_cost),
      .rsp_last          (rsp_last),
      .mismatches        (mismatches),
      .pending           (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 29);
   end

   // small weights often, so that ties between keys show up
   function automatic logic [15:0] random_weight();
      int kind;
      kind = $urandom_range(7);
      unique case (kind)
         0:       return 16'd0;
         1, 2, 3: return 16'($urandom_range(6, 1));
         4:       return 16'hFFFF - 16'($urandom_range(3));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_entry(input logic [2:0] row, input logic [2:0] col,
                             input logic [15:0] weight, input logic fin);
      while (!calm && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_row        <= row;
      req_col        <= col;
      req_weight     <= weight;
      req_last_entry <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      entries_sent++;
   endtask

   initial begin
      int n;
      int mode;
      int u;
      int v;
      logic [15:0] w;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_row        <= 3'd0;
      req_col        <= 3'd0;
      req_weight     <= 16'd0;
      req_last_entry <= 1'b0;
      calm           <= 1'b0;
      entries_sent   = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty graph: every vertex unreachable
      send_entry(3'd0, 3'd0, 16'd0, 1'b1);
      // self loop at the top corner and a one-way max weight edge
      send_entry(3'd7, 3'd7, 16'hFFFF, 1'b0);
      send_entry(3'd0, 3'd7, 16'hFFFF, 1'b1);
      // equal keys, lowest index wins
      send_entry(3'd0, 3'd1, 16'd5, 1'b0);
      send_entry(3'd0, 3'd2, 16'd5, 1'b0);
      send_entry(3'd1, 3'd3, 16'd3, 1'b0);
      send_entry(3'd2, 3'd3, 16'd3, 1'b1);
      // asymmetric matrix: the back edge into vertex 0 goes unused
      send_entry(3'd1, 3'd0, 16'd9, 1'b0);
      send_entry(3'd0, 3'd2, 16'd4, 1'b0);
      send_entry(3'd2, 3'd1, 16'd7, 1'b1);
      // full-weight chain drives total_cost near its top
      for (int k = 0; k < 7; k++) send_entry(3'(k), 3'(k + 1), 16'hFFFF, k == 6);
      // overwrites, one of them removing an edge
      send_entry(3'd0, 3'd1, 16'd100, 1'b0);
      send_entry(3'd0, 3'd1, 16'd1, 1'b0);
      send_entry(3'd1, 3'd2, 16'h8000, 1'b0);
      send_entry(3'd0, 3'd4, 16'h7FFF, 1'b0);
      send_entry(3'd0, 3'd4, 16'd0, 1'b1);

      while (entries_sent < ITEM_TARGET) begin
         calm <= (entries_sent >= 120 && entries_sent < 180);
         mode = $urandom_range(9);
         if (mode < 6) begin
            // random undirected edges
            n = $urandom_range(14, 3);
            for (int k = 0; k < n; k++) begin
               u = $urandom_range(7);
               v = $urandom_range(7);
               w = random_weight();
               send_entry(3'(u), 3'(v), w, 1'b0);
               send_entry(3'(v), 3'(u), w, k == n - 1);
            end
         end else if (mode < 8) begin
            // random tree: each vertex hangs off an earlier one
            for (int k = 1; k < 8; k++) begin
               u = $urandom_range(k - 1);
               w = random_weight();
               send_entry(3'(k), 3'(u), w, 1'b0);
               send_entry(3'(u), 3'(k), w, k == 7);
            end
         end else begin
            // loose one-way entries
            n = $urandom_range(10, 1);
            for (int k = 0; k < n; k++) begin
               send_entry(3'($urandom_range(7)), 3'($urandom_range(7)),
                          random_weight(), k == n - 1);
            end
         end
      end
      req_valid <= 1'b0;
      calm      <= 1'b0;

      // let the checker queue the last run before watching it drain
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+sv
sv/prim_mst_pkg.sv
sv/prim_mst_mem.sv
sv/prim_mst_keys.sv
sv/prim_minimum_spanning_tree.sv
sv/prim_mst_checker.sv
tb/prim_minimum_spanning_tree_checker.sv
tb/prim_minimum_spanning_tree_tb.sv
